// ----- hdl/json_subset_tokenizer_unit_assert.svh -----
// assertion macros shared by the tokenizer modules
`ifndef JSON_SUBSET_TOKENIZER_UNIT_ASSERT_SVH
`define JSON_SUBSET_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define JST_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("jst: implication check failed");

// next-cycle implication, checked at every rising edge out of reset
`define JST_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("jst: next-cycle check failed");

`else

`define JST_ASSERT_IMPLY(name, clk, rst_n, pre, post)

`define JST_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

// ----- hdl/jst_pkg.sv -----
package jst_pkg;

	// token kinds
	localparam logic [3:0] KIND_NUM     = 4'd0;
	localparam logic [3:0] KIND_STR     = 4'd1;
	localparam logic [3:0] KIND_COMMA   = 4'd2;
	localparam logic [3:0] KIND_COLON   = 4'd3;
	localparam logic [3:0] KIND_LBRACE  = 4'd4;
	localparam logic [3:0] KIND_RBRACE  = 4'd5;
	localparam logic [3:0] KIND_LBRACK  = 4'd6;
	localparam logic [3:0] KIND_RBRACK  = 4'd7;
	localparam logic [3:0] KIND_TRUE    = 4'd8;
	localparam logic [3:0] KIND_FALSE   = 4'd9;
	localparam logic [3:0] KIND_BADWORD = 4'd10;
	localparam logic [3:0] KIND_OPENSTR = 4'd11;
	localparam logic [3:0] KIND_NONE    = 4'd15;

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// keyword patterns, newest byte lowest
	localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
	localparam logic [39:0] WORD_FALSE = 40'h66616C7365;

	// one result item
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] value;
		logic       byte_valid;
		logic       first;
		logic       last;
	} jst_result_t;

	// one queue entry: one or two results of one input item
	typedef struct packed {
		jst_result_t res0;
		jst_result_t res1;
		logic        two;
	} jst_entry_t;

	function automatic jst_result_t make_result(input logic [3:0] kind, input logic [7:0] value,
			input logic byte_valid, input logic first, input logic last);
		jst_result_t r;
		r.kind       = kind;
		r.value      = value;
		r.byte_valid = byte_valid;
		r.first      = first;
		r.last       = last;
		return r;
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] b);
		logic [3:0] k;
		unique case (b)
			CH_COMMA:  k = KIND_COMMA;
			CH_COLON:  k = KIND_COLON;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LBRACK: k = KIND_LBRACK;
			CH_RBRACK: k = KIND_RBRACK;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

// ----- hdl/jst_front.sv -----
`include "json_subset_tokenizer_unit_assert.svh"

module jst_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               end_of_text,
	output logic               push,
	output jst_pkg::jst_entry_t push_entry
);
	import jst_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_STR  = 2'd2;

	logic [1:0]  mode_q, mode_d;
	logic [39:0] word_q, word_d;
	logic [2:0]  len_q, len_d;
	logic        ovf_q, ovf_d;
	logic        sas_q, sas_d;

	logic [2:0]  v;
	jst_result_t c0, c1, c2;
	logic        is_digit, is_sep, is_quote, boundary;
	logic [3:0]  pk;
	logic [3:0]  word_kind;

	// byte classes
	always_comb begin
		pk       = punct_kind(in_byte);
		is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		is_quote = (in_byte == CH_DQUOTE);
		is_sep   = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR) ||
			(in_byte == CH_LF) || (in_byte == CH_SQUOTE);
		boundary = is_sep || is_digit || is_quote || (pk != KIND_NONE);
	end

	// word check
	always_comb begin
		word_kind = KIND_BADWORD;
		if (!ovf_q && len_q == 3'd4 && word_q == WORD_TRUE) begin
			word_kind = KIND_TRUE;
		end else if (!ovf_q && len_q == 3'd5 && word_q == WORD_FALSE) begin
			word_kind = KIND_FALSE;
		end
	end

	// classify the byte: candidate results in order and next scan state
	always_comb begin
		mode_d = mode_q;
		word_d = word_q;
		len_d  = len_q;
		ovf_d  = ovf_q;
		sas_d  = sas_q;
		v      = 3'b000;
		c0     = '0;
		c1     = '0;
		c2     = '0;
		if (end_of_text) begin
			if (mode_q == MODE_STR) begin
				v[0] = 1'b1;
				c0   = make_result(KIND_OPENSTR, 8'd0, 1'b0, sas_q, 1'b1);
			end else if (mode_q == MODE_NUM) begin
				v[0] = 1'b1;
				c0   = make_result(KIND_NUM, 8'd0, 1'b0, 1'b0, 1'b1);
			end
			mode_d = MODE_IDLE;
			word_d = '0;
			len_d  = '0;
			ovf_d  = 1'b0;
			sas_d  = 1'b0;
		end else if (mode_q == MODE_STR) begin
			v[0]  = 1'b1;
			sas_d = 1'b0;
			if (is_quote) begin
				c0     = make_result(KIND_STR, 8'd0, 1'b0, sas_q, 1'b1);
				mode_d = MODE_IDLE;
			end else begin
				c0 = make_result(KIND_STR, in_byte, 1'b1, sas_q, 1'b0);
			end
		end else if (mode_q == MODE_NUM && is_digit) begin
			v[0] = 1'b1;
			c0   = make_result(KIND_NUM, in_byte, 1'b1, 1'b0, 1'b0);
		end else begin
			// a non-digit closes a number, then the byte is handled as in idle
			if (mode_q == MODE_NUM) begin
				v[0]   = 1'b1;
				c0     = make_result(KIND_NUM, 8'd0, 1'b0, 1'b0, 1'b1);
				mode_d = MODE_IDLE;
			end
			if (!boundary) begin
				if (len_q >= 3'd5) begin
					ovf_d = 1'b1;
				end else begin
					len_d = len_q + 3'd1;
				end
				word_d = {word_q[31:0], in_byte};
			end else begin
				if (len_q != 3'd0 || ovf_q) begin
					v[1] = 1'b1;
					c1   = make_result(word_kind, 8'd0, 1'b0, 1'b1, 1'b1);
				end
				word_d = '0;
				len_d  = '0;
				ovf_d  = 1'b0;
				if (pk != KIND_NONE) begin
					v[2] = 1'b1;
					c2   = make_result(pk, 8'd0, 1'b0, 1'b1, 1'b1);
				end else if (is_digit) begin
					v[2]   = 1'b1;
					c2     = make_result(KIND_NUM, in_byte, 1'b1, 1'b1, 1'b0);
					mode_d = MODE_NUM;
				end else if (is_quote) begin
					mode_d = MODE_STR;
					sas_d  = 1'b1;
				end
			end
		end
	end

	// pack the first two candidates into one entry
	always_comb begin
		push_entry = '0;
		if (v[0]) begin
			push_entry.res0 = c0;
			push_entry.res1 = v[1] ? c1 : c2;
			push_entry.two  = v[1] || v[2];
		end else if (v[1]) begin
			push_entry.res0 = c1;
			push_entry.res1 = c2;
			push_entry.two  = v[2];
		end else begin
			push_entry.res0 = c2;
			push_entry.res1 = c2;
			push_entry.two  = 1'b0;
		end
		push = accept && (v != 3'b000);
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			word_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			sas_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			word_q <= word_d;
			len_q  <= len_d;
			ovf_q  <= ovf_d;
			sas_q  <= sas_d;
		end
	end

	`JST_ASSERT_IMPLY(a_len_range, clk, arst_n, 1'b1, (len_q != 3'd6) && (len_q != 3'd7))
	`JST_ASSERT_NEXT(a_eot_clears, clk, arst_n, accept && end_of_text, (mode_q == MODE_IDLE) && (len_q == 3'd0) && !ovf_q)
	`JST_ASSERT_IMPLY(a_mode_code, clk, arst_n, 1'b1, mode_q != 2'd3)

endmodule

// ----- hdl/jst_queue.sv -----
`include "json_subset_tokenizer_unit_assert.svh"

module jst_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jst_pkg::jst_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output jst_pkg::jst_entry_t head,
	output logic                empty
);
	import jst_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jst_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// flags and head
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`JST_ASSERT_IMPLY(a_no_overflow, clk, arst_n, full, !push)
	`JST_ASSERT_IMPLY(a_empty_ptrs, clk, arst_n, empty, rd_ptr_q == wr_ptr_q)

endmodule

// ----- hdl/jst_back.sv -----
`include "json_subset_tokenizer_unit_assert.svh"

module jst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  jst_pkg::jst_entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output jst_pkg::jst_result_t out_res
);
	import jst_pkg::*;

	logic        out_valid_q;
	jst_result_t out_res_q;
	logic        sel_q;
	logic        load;
	logic        entry_done;
	jst_result_t cur;

	// pick the next result of the head entry
	always_comb begin
		load       = !out_valid_q || !out_stall;
		cur        = sel_q ? head.res1 : head.res0;
		entry_done = !head.two || sel_q;
		pop        = load && !empty && entry_done;
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				sel_q <= !entry_done;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_res_q <= cur;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`JST_ASSERT_IMPLY(a_second_pending, clk, arst_n, sel_q, !empty && head.two)

endmodule

// ----- hdl/json_subset_tokenizer_unit.sv -----
// streaming tokenizer for a subset of json text, one byte per item
// input channel: in_valid / in_stall with in_byte and end_of_text; an item is
// taken at an edge with in_valid high and in_stall low; end_of_text closes an
// open number, flags an open string and drops a pending word (in_byte ignored)
// output channel: out_valid / out_stall with token_kind, value_byte,
// byte_valid, token_first and token_last; one result item per taken edge
// each input item gives zero, one or two results; the front classifies the
// byte in the cycle it is taken and writes its results as one entry into a
// QUEUE_DEPTH-entry queue, the back drains it one result per cycle unless held
// by out_stall; the results of an item pass from a queue slot to the output
// register, a second result of the same entry behind the first
// throughput: one item per cycle while the queue has room, bounded by one
// result per cycle on the output register, so two-result items fill the queue
// in_stall rises while the queue is full; out_stall holds the output register
// and backs up the queue, items with no result still pass while it has room
// reset: asynchronous, clears scan state, queue and output valid; the queue
// is empty out of reset, so in_stall is low and the block takes items
module json_subset_tokenizer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] token_kind,
	output logic [7:0] value_byte,
	output logic       byte_valid,
	output logic       token_first,
	output logic       token_last
);
	import jst_pkg::*;

	logic        accept;
	logic        push, pop, full, empty;
	jst_entry_t  push_entry, head;
	jst_result_t out_res;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	// classify bytes and track scan state
	jst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.push       (push),
		.push_entry (push_entry)
	);

	// entries waiting for the output side
	jst_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// serialize entries onto the result channel
	jst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign token_kind  = out_res.kind;
	assign value_byte  = out_res.value;
	assign byte_valid  = out_res.byte_valid;
	assign token_first = out_res.first;
	assign token_last  = out_res.last;

endmodule
